FILE: rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the hysteresis gate.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: always");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/sshg_pkg.sv
// Package for the speech segment hysteresis gate: widths, register map,
// reset values and the configuration and state structs. No dependencies.
`default_nettype none

package sshg_pkg;

   localparam int PROB_W  = 16;
   localparam int POS_W   = 32;
   localparam int WIN_W   = 13;
   localparam int LEN_W   = 20;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   localparam logic [PROB_W-1:0] THRESHOLD_RST   = 16'd32768;
   localparam logic [PROB_W-1:0] MARGIN_RST      = 16'd9830;
   localparam logic [WIN_W-1:0]  WINDOW_RST      = 13'd512;
   localparam logic [LEN_W-1:0]  MIN_SPEECH_RST  = 20'd4000;
   localparam logic [LEN_W-1:0]  MIN_SILENCE_RST = 20'd8000;

   typedef enum logic [2:0] {
      REG_THRESHOLD   = 3'd0,
      REG_MARGIN      = 3'd1,
      REG_WINDOW      = 3'd2,
      REG_MIN_SPEECH  = 3'd3,
      REG_MIN_SILENCE = 3'd4
   } sshg_reg_type;

   typedef struct packed {
      logic [PROB_W-1:0] threshold;
      logic [PROB_W-1:0] release_margin;
      logic [WIN_W-1:0]  window_length;
      logic [LEN_W-1:0]  min_speech_length;
      logic [LEN_W-1:0]  min_silence_length;
   } sshg_cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] start_mark;
      logic [POS_W-1:0] end_mark;
      logic             speaking;
   } sshg_state_type;

endpackage

`default_nettype wire

FILE: rtl/core/speech_segment_hysteresis_gate_unit.sv
// Top level of the speech segment hysteresis gate: input register, decision
// logic, gate state and result register. Depends on sshg_pkg, sshg_csr,
// sshg_decide and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// One speech probability (unsigned Q0.16) enters per req transfer and yields
// exactly one is_speech result on rsp, in order. The block takes a new window
// every cycle while rsp is not stalled. A window taken into the input register
// passes through the decision compare and position add into the result
// register once the result register is free, and its result is then presented
// on rsp. The gate state (position, start and end marks, speaking flag) is
// updated as each window leaves the input register, so back-to-back windows
// see each other's effect without bubbles. A stall on rsp holds the result
// register; req_tready drops only while both registers are full and rsp is
// stalled.
// Registers sit at byte offsets 0x00 threshold, 0x04 release margin,
// 0x08 window length, 0x0C minimum speech length, 0x10 minimum silence
// length; write them only while no window is in flight.
module speech_segment_hysteresis_gate_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [15:0]                  req_tdata,   // [15:0] speech_prob
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [0] is_speech, [7:1] zero
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [sshg_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire  [sshg_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [sshg_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import sshg_pkg::*;

   sshg_cfg_type      cfg;
   sshg_state_type    state_ff;
   sshg_state_type    state_in;
   logic              dec_speech;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [PROB_W-1:0] in_prob_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              out_speech_ff;

   logic              out_free;
   logic              advance;
   logic              req_xfer;

   assign csr_pready = 1'b1;

   sshg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   sshg_decide u_decide (
      .cfg       (cfg),
      .cur       (state_ff),
      .prob      (in_prob_ff),
      .nxt       (state_in),
      .is_speech (dec_speech)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_prob_ff <= req_tdata[PROB_W-1:0];
      end
      if (advance) begin
         out_speech_ff <= dec_speech;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_speech_ff};

   // Speech turns on only together with a speech result entering the output.
   `ASSERT_SAME(a_rise_speech, clock, reset, $rose(state_ff.speaking),
      rsp_tvalid && rsp_tdata[0])
   // Speech turns off only together with a silence result entering the output.
   `ASSERT_SAME(a_fall_silence, clock, reset, $fell(state_ff.speaking),
      rsp_tvalid && !rsp_tdata[0])
   // A silence start is only tracked while speaking.
   `ASSERT_ALWAYS(a_end_mark_idle, clock, reset,
      state_ff.speaking || state_ff.end_mark == '0)
   // Position moves only when a window is decided.
   `ASSERT_NEXT(a_pos_hold, clock, reset, !advance,
      $stable(state_ff.position))

endmodule

`default_nettype wire

FILE: rtl/core/sshg_csr.sv
// Configuration register file of the hysteresis gate, APB-style access.
// Depends on sshg_pkg.
`default_nettype none

module sshg_csr (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [sshg_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire  [sshg_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [sshg_pkg::DATA_W-1:0]  csr_prdata,
   output sshg_pkg::sshg_cfg_type       cfg
);
   import sshg_pkg::*;

   sshg_cfg_type cfg_ff;
   sshg_cfg_type cfg_in;
   sshg_reg_type reg_sel;
   logic         wr_en;

   assign reg_sel = sshg_reg_type'(csr_paddr[ADDR_W-1:2]);
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_THRESHOLD:   cfg_in.threshold          = csr_pwdata[PROB_W-1:0];
            REG_MARGIN:      cfg_in.release_margin     = csr_pwdata[PROB_W-1:0];
            REG_WINDOW:      cfg_in.window_length      = csr_pwdata[WIN_W-1:0];
            REG_MIN_SPEECH:  cfg_in.min_speech_length  = csr_pwdata[LEN_W-1:0];
            REG_MIN_SILENCE: cfg_in.min_silence_length = csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold          <= THRESHOLD_RST;
         cfg_ff.release_margin     <= MARGIN_RST;
         cfg_ff.window_length      <= WINDOW_RST;
         cfg_ff.min_speech_length  <= MIN_SPEECH_RST;
         cfg_ff.min_silence_length <= MIN_SILENCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_THRESHOLD:   csr_prdata = DATA_W'(cfg_ff.threshold);
         REG_MARGIN:      csr_prdata = DATA_W'(cfg_ff.release_margin);
         REG_WINDOW:      csr_prdata = DATA_W'(cfg_ff.window_length);
         REG_MIN_SPEECH:  csr_prdata = DATA_W'(cfg_ff.min_speech_length);
         REG_MIN_SILENCE: csr_prdata = DATA_W'(cfg_ff.min_silence_length);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sshg_decide.sv
// Per-window decision logic: next gate state and speech flag from the
// current state, the configuration and one probability. Depends on sshg_pkg.
`default_nettype none

module sshg_decide (
   input  sshg_pkg::sshg_cfg_type       cfg,
   input  sshg_pkg::sshg_state_type     cur,
   input  wire  [sshg_pkg::PROB_W-1:0]  prob,
   output sshg_pkg::sshg_state_type     nxt,
   output logic                         is_speech
);
   import sshg_pkg::*;

   logic [PROB_W-1:0] lo;
   logic              above;
   logic              below;
   logic [POS_W-1:0]  pos;
   logic [POS_W-1:0]  em_run;
   logic [POS_W-1:0]  speech_span;
   logic [POS_W-1:0]  silence_span;

   assign lo    = (cfg.release_margin >= cfg.threshold) ? '0
                : cfg.threshold - cfg.release_margin;
   assign above = prob > cfg.threshold;
   assign below = prob < cfg.threshold;
   assign pos   = cur.position + POS_W'(cfg.window_length);

   // em_run is only used on the silence branch, where above is false
   assign em_run       = (cur.end_mark == '0) ? pos : cur.end_mark;
   assign speech_span  = pos - cur.start_mark;
   assign silence_span = pos - em_run;

   always_comb begin
      nxt          = cur;
      nxt.position = pos;
      is_speech    = 1'b0;
      if (above && cur.end_mark != '0) begin
         nxt.end_mark = '0;
      end
      if (above && cur.start_mark == '0) begin
         nxt.start_mark = pos;
      end else if (above && !cur.speaking) begin
         if (speech_span >= POS_W'(cfg.min_speech_length)) begin
            nxt.speaking = 1'b1;
            is_speech    = 1'b1;
         end
      end else if (below && !cur.speaking) begin
         nxt.start_mark = '0;
         nxt.end_mark   = '0;
      end else if (cur.speaking && prob > lo) begin
         is_speech = 1'b1;
      end else if (below && cur.speaking) begin
         if (silence_span < POS_W'(cfg.min_silence_length)) begin
            nxt.end_mark = em_run;
            is_speech    = 1'b1;
         end else begin
            nxt.start_mark = '0;
            nxt.end_mark   = '0;
            nxt.speaking   = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire
